// ----- hdl/fstp_pkg.sv -----
// Shared types, constants and weight table for the fair-share task picker.
package fstp_pkg;

  localparam int unsigned NICE_MAX = 39;
  localparam int unsigned NICE_DEFAULT = 20;
  localparam int unsigned W_MAX = 88761;
  localparam int unsigned W_MIN = 15;
  localparam int unsigned PERIOD_RESET = 1000 / 100;
  localparam int unsigned SCALE_RESET = 1024 * 1000;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_NICE  = 3'd1,
    OP_SLEEP = 3'd2,
    OP_WAKE  = 3'd3,
    OP_PICK  = 3'd4,
    OP_KILL  = 3'd5
  } op_t;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_SCALE  = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  slot;
    logic [15:0] task_id;
    logic [2:0]  task_state;
    logic [5:0]  nice_level;
    logic [30:0] virtual_time;
    logic [31:0] channel;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [15:0] chosen_id;
    logic [9:0]  timeslice;
  } rsp_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [23:0] data;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic scan_start;
    logic scan;
    logic advance;
    logic div_start;
    logic wake_write;
    logic apply;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic any_run;
    logic wake_hit;
    logic div_done;
  } sts_t;

  function automatic logic [16:0] nice_weight(input logic [5:0] n);
    logic [16:0] w;
    case (n)
      6'd0: w = 17'd88761;  6'd1: w = 17'd71755;  6'd2: w = 17'd56483;
      6'd3: w = 17'd46273;  6'd4: w = 17'd36291;  6'd5: w = 17'd29154;
      6'd6: w = 17'd23254;  6'd7: w = 17'd18705;  6'd8: w = 17'd14949;
      6'd9: w = 17'd11916;  6'd10: w = 17'd9548;  6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;  6'd13: w = 17'd4904;  6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;  6'd16: w = 17'd2501;  6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;  6'd19: w = 17'd1277;  6'd20: w = 17'd1024;
      6'd21: w = 17'd820;   6'd22: w = 17'd655;   6'd23: w = 17'd526;
      6'd24: w = 17'd423;   6'd25: w = 17'd335;   6'd26: w = 17'd272;
      6'd27: w = 17'd215;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
      6'd30: w = 17'd110;   6'd31: w = 17'd87;    6'd32: w = 17'd70;
      6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
      6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
      default: w = 17'(W_MIN);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/fstp_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration.
interface fstp_req_if import fstp_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fstp_rsp_if import fstp_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fstp_cfg_if import fstp_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fstp_div.sv -----
// Restoring divider, one quotient bit per cycle.
module fstp_div import fstp_pkg::*; #(
  parameter int unsigned WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);
  localparam int unsigned CW = $clog2(WIDTH + 1);
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    count;
  logic             busy;
  logic [WIDTH:0]   trial;

  assign trial = {rem, quo[WIDTH-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[WIDTH]) begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[WIDTH-2:0], quo[WIDTH-1]};
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- hdl/fstp_datapath.sv -----
// Task table, scan registers and arithmetic for the task picker.
module fstp_datapath import fstp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  req_t        req,
  input  logic [9:0]  period,
  input  logic [23:0] scale,
  output sts_t        sts,
  output rsp_t        rsp
);
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned DW = 27;
  localparam int unsigned TW = 17 + $clog2(TABLE_ENTRIES + 1);

  logic [2:0]  entry_state [TABLE_ENTRIES];
  logic [15:0] entry_id [TABLE_ENTRIES];
  logic [5:0]  entry_nice [TABLE_ENTRIES];
  logic [30:0] entry_vtime [TABLE_ENTRIES];
  logic [31:0] entry_channel [TABLE_ENTRIES];
  logic        entry_killed [TABLE_ENTRIES];

  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic [2:0]    rd_state;
  logic [15:0]   rd_id;
  logic [5:0]    rd_nice;
  logic [30:0]   rd_vtime;
  logic [31:0]   rd_chan;
  logic          any_run;
  logic [30:0]   vmin;
  logic [IW-1:0] best;
  logic [16:0]   best_w;
  logic [15:0]   best_id;
  logic [TW-1:0] total;
  logic          found;
  logic [IW-1:0] hit;
  logic [2:0]    hit_state;
  logic [DW-1:0] div_a;
  logic [DW-1:0] div_b;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic          slot_ok;
  logic          nice_ok;
  logic          is_last;
  logic [16:0]   w_rd;
  logic          is_run;
  logic          wake_hit;
  logic [30:0]   credit;
  logic [30:0]   vtime_woken;
  logic [IW-1:0] wr_addr;
  logic          we_state;
  logic          we_id;
  logic          we_nice;
  logic          we_vtime;
  logic          we_chan;
  logic          we_killed;
  logic [2:0]    wr_state;
  logic [15:0]   wr_id;
  logic [5:0]    wr_nice;
  logic [30:0]   wr_vtime;
  logic          wr_killed;

  assign slot_ok = {3'b0, req.slot} < 9'(TABLE_ENTRIES);
  assign nice_ok = req.nice_level <= 6'(NICE_MAX);
  assign is_last = idx == IW'(TABLE_ENTRIES - 1);
  assign w_rd = nice_weight(rd_nice);
  assign is_run = rd_state == ST_RUNNABLE;
  assign wake_hit = rd_state == ST_SLEEPING && rd_chan == req.channel;
  assign credit = 31'(div_q);
  assign vtime_woken = (vmin < credit) ? '0 : vmin - credit;
  assign div_a = (req.opcode == OP_PICK) ?
                 DW'(period) * DW'(best_w) + DW'(total) - DW'(1) : DW'(scale);
  assign div_b = (req.opcode == OP_PICK) ? DW'(total) : DW'(w_rd);

  fstp_div #(.WIDTH(DW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    sts.last = is_last;
    sts.any_run = any_run;
    sts.wake_hit = wake_hit;
    sts.div_done = div_done;
  end

  always_comb begin
    idx_next = idx;
    if (cmd.scan_start) idx_next = '0;
    else if (cmd.advance) idx_next = is_last ? '0 : idx + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      any_run <= 1'b0;
      vmin <= '0;
      best <= '0;
      best_w <= '0;
      best_id <= '0;
      total <= '0;
      found <= 1'b0;
      hit <= '0;
      hit_state <= ST_UNUSED;
    end else if (cmd.scan) begin
      if (is_run) begin
        total <= total + TW'(w_rd);
        if (!any_run || rd_vtime < vmin) begin
          vmin <= rd_vtime;
          best <= idx;
          best_w <= w_rd;
          best_id <= rd_id;
        end
        any_run <= 1'b1;
      end
      if (!found && rd_id == req.task_id) begin
        found <= 1'b1;
        hit <= idx;
        hit_state <= rd_state;
      end
    end
  end

  always_comb begin
    wr_addr = idx;
    we_state = 1'b0;
    we_id = 1'b0;
    we_nice = 1'b0;
    we_vtime = 1'b0;
    we_chan = 1'b0;
    we_killed = 1'b0;
    wr_state = ST_UNUSED;
    wr_id = '0;
    wr_nice = 6'(NICE_DEFAULT);
    wr_vtime = '0;
    wr_killed = 1'b0;
    if (cmd.clear) begin
      we_state = 1'b1;
      we_id = 1'b1;
      we_nice = 1'b1;
      we_vtime = 1'b1;
      we_killed = 1'b1;
    end else if (cmd.wake_write) begin
      we_vtime = 1'b1;
      we_state = 1'b1;
      wr_vtime = vtime_woken;
      wr_state = ST_RUNNABLE;
    end else if (cmd.apply) begin
      case (req.opcode)
        OP_LOAD: if (nice_ok && slot_ok) begin
          wr_addr = IW'(req.slot);
          we_state = 1'b1;
          we_id = 1'b1;
          we_nice = 1'b1;
          we_vtime = 1'b1;
          we_chan = 1'b1;
          we_killed = 1'b1;
          wr_state = req.task_state;
          wr_id = req.task_id;
          wr_nice = req.nice_level;
          wr_vtime = req.virtual_time;
        end
        OP_NICE: if (found && nice_ok) begin
          wr_addr = hit;
          we_nice = 1'b1;
          wr_nice = req.nice_level;
        end
        OP_SLEEP: if (slot_ok) begin
          wr_addr = IW'(req.slot);
          we_state = 1'b1;
          we_chan = 1'b1;
          wr_state = ST_SLEEPING;
        end
        OP_PICK: if (any_run) begin
          wr_addr = best;
          we_state = 1'b1;
          wr_state = ST_RUNNING;
        end
        OP_KILL: if (found) begin
          wr_addr = hit;
          we_killed = 1'b1;
          wr_killed = 1'b1;
          if (hit_state == ST_SLEEPING) begin
            we_state = 1'b1;
            wr_state = ST_RUNNABLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_state <= entry_state[idx_next];
    rd_id <= entry_id[idx_next];
    rd_nice <= entry_nice[idx_next];
    rd_vtime <= entry_vtime[idx_next];
    rd_chan <= entry_channel[idx_next];
    if (we_state) entry_state[wr_addr] <= wr_state;
    if (we_id) entry_id[wr_addr] <= wr_id;
    if (we_nice) entry_nice[wr_addr] <= wr_nice;
    if (we_vtime) entry_vtime[wr_addr] <= wr_vtime;
    if (we_chan) entry_channel[wr_addr] <= req.channel;
    if (we_killed) entry_killed[wr_addr] <= wr_killed;
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp <= '0;
      case (req.opcode)
        OP_LOAD: if (!nice_ok) rsp.status <= STAT_RANGE;
        OP_NICE: begin
          if (!found) rsp.status <= STAT_NOTFOUND;
          else if (!nice_ok) rsp.status <= STAT_RANGE;
        end
        OP_KILL: if (!found) rsp.status <= STAT_NOTFOUND;
        OP_PICK: begin
          if (!any_run) begin
            rsp.status <= STAT_NOTFOUND;
          end else begin
            rsp.chosen_slot <= 6'(best);
            rsp.chosen_id <= best_id;
            rsp.timeslice <= 10'(div_q);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/fstp_ctrl.sv -----
// Sequencer that steps the table clear, scan, divider and wakeup pass.
module fstp_ctrl import fstp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  op_t  opcode,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_WAKE  = 9'b000100000,
    S_WWAIT = 9'b001000000,
    S_APPLY = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        cmd.advance = 1'b1;
        if (sts.last) state_next = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        cmd.advance = 1'b1;
        if (sts.last) begin
          if (opcode == OP_PICK) state_next = S_DIV;
          else if (opcode == OP_WAKE) state_next = S_WAKE;
          else state_next = S_APPLY;
        end
      end
      S_DIV: begin
        if (sts.any_run) begin
          cmd.div_start = 1'b1;
          state_next = S_WAIT;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_WAIT: if (sts.div_done) state_next = S_APPLY;
      S_WAKE: begin
        if (sts.wake_hit) begin
          cmd.div_start = 1'b1;
          state_next = S_WWAIT;
        end else begin
          cmd.advance = 1'b1;
          if (sts.last) state_next = S_APPLY;
        end
      end
      S_WWAIT: if (sts.div_done) begin
        cmd.wake_write = 1'b1;
        cmd.advance = 1'b1;
        state_next = sts.last ? S_APPLY : S_WAKE;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end
endmodule

// ----- hdl/fair_share_task_picker.sv -----
// Top level of the fair-share task picker.
// Requests arrive on req (opcode, slot, pid, state, nice, vtime, channel);
// one result per request leaves on rsp (status, slot, pid, timeslice).
// Configuration writes on cfg set the scheduling period (index 0) and the
// wakeup credit scale (index 1); write them only while no request is open.
// After reset the table is cleared one slot a cycle, and req is not ready
// until the clear is done; then every slot holds state unused, pid 0, nice 20,
// vtime 0, and period 10 and scale 1024000 are restored.
// Every request scans the table one slot a cycle; an apply step then writes
// the update and registers the result for the transfer on rsp.
// A pick with a runnable task first runs the 27-step divider for the
// timeslice, and a pick with nothing runnable goes straight to the apply step.
// A wakeup makes a second pass over the table, one slot a cycle while no
// sleeper wakes, and waits on the divider for each sleeper that wakes.
// One request is in flight at a time; req is ready again the cycle after the
// result transfer.
// A stalled receiver holds the result steady and keeps req not ready.
module fair_share_task_picker import fstp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input logic         clk,
  input logic         rst,
  fstp_req_if.sink    req,
  fstp_rsp_if.source  rsp,
  fstp_cfg_if.sink    cfg
);
  cmd_t        cmd;
  sts_t        sts;
  logic [9:0]  period;
  logic [23:0] scale;
  logic        in_fire;
  req_t        held;

  assign in_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= 10'(PERIOD_RESET);
      scale <= 24'(SCALE_RESET);
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_PERIOD: period <= cfg.data.data[9:0];
        CFG_SCALE: scale <= cfg.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) held <= req.data;
  end

  fstp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .opcode(op_t'(held.opcode)),
    .out_ready(rsp.ready), .sts(sts), .cmd(cmd),
    .in_ready(req.ready), .out_valid(rsp.valid)
  );

  fstp_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(held), .period(period),
    .scale(scale), .sts(sts), .rsp(rsp.data)
  );

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !req.ready) else $error("request not taken");
endmodule
